@@ rtl/lph_pkg.sv @@
package lph_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_OUT_W  = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_READ,
    S_HOLD
  } seq_state_t;

  typedef struct packed {
    op_t               opcode;
    logic [KEY_W-1:0]  key_in;
    logic [VAL_W-1:0]  value_in;
    logic [IDX_W-1:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     slot_index;
    logic                 slot_valid;
    logic [KEY_W-1:0]     slot_key;
    logic [VAL_W-1:0]     slot_value;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [KEY_W-1:0]  wkey;
    logic [VAL_W-1:0]  wval;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == SLOT_W'(TABLE_SIZE - 1)) ? '0 : s + 1'b1;
    return n;
  endfunction

  function automatic out_item_t mk_result(input status_t          st,
                                          input logic [IDX_W-1:0] idx,
                                          input logic             vld,
                                          input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v,
                                          input logic [CNT_W-1:0] cnt);
    out_item_t r;
    r.status      = st;
    r.slot_index  = idx;
    r.slot_valid  = vld;
    r.slot_key    = k;
    r.slot_value  = v;
    r.entry_count = CNT_OUT_W'(cnt);
    return r;
  endfunction

endpackage

@@ rtl/lph_slot_ram.sv @@
module lph_slot_ram
  import lph_pkg::*;
(
  input  logic             clk,
  input  ram_req_t         ram_req,
  output logic [KEY_W-1:0] rd_key,
  output logic [VAL_W-1:0] rd_val
);

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  logic [VAL_W-1:0] val_mem [TABLE_SIZE];
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;

  always_ff @(posedge clk) begin
    if (ram_req.we) begin
      key_mem[ram_req.waddr] <= ram_req.wkey;
      val_mem[ram_req.waddr] <= ram_req.wval;
    end
    rd_key_r <= key_mem[ram_req.raddr];
    rd_val_r <= val_mem[ram_req.raddr];
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

@@ rtl/lph_seq.sv @@
module lph_seq
  import lph_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_data,
  output logic             in_stall,
  output ram_req_t         ram_req,
  input  logic [KEY_W-1:0] rd_key,
  input  logic [VAL_W-1:0] rd_val,
  output logic             res_valid,
  output out_item_t        res_data,
  input  logic             res_ready
);

  seq_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [SLOT_W-1:0] cmp_ptr_r, cmp_ptr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TABLE_SIZE-1:0] used_r, used_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [IDX_W-1:0]  sel_r, sel_nxt;
  out_item_t         res_r, res_nxt;
  logic [SLOT_W-1:0] home;
  logic              hit;
  logic              rd_vld;

  assign home = SLOT_W'(in_data.key_in % TABLE_SIZE);
  assign hit  = cmp_vld_r && used_r[cmp_ptr_r] && (rd_key == key_r);
  assign rd_vld = (32'(sel_r) < TABLE_SIZE) && used_r[SLOT_W'(sel_r)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      iss_cnt_r <= '0;
      count_r   <= '0;
      used_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      count_r   <= count_nxt;
      used_r    <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    cmp_ptr_r <= cmp_ptr_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    sel_r     <= sel_nxt;
    res_r     <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cmp_ptr_nxt   = cmp_ptr_r;
    cmp_vld_nxt   = 1'b0;
    iss_cnt_nxt   = iss_cnt_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    sel_nxt       = sel_r;
    res_nxt       = res_r;
    in_stall      = (state_r != S_IDLE);
    res_valid     = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = ptr_r;
    ram_req.wkey  = key_r;
    ram_req.wval  = val_r;
    ram_req.raddr = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        ram_req.raddr = SLOT_W'(in_data.slot_select);
        if (in_valid) begin
          key_nxt     = in_data.key_in;
          val_nxt     = in_data.value_in;
          sel_nxt     = in_data.slot_select;
          ptr_nxt     = home;
          iss_cnt_nxt = '0;
          unique case (in_data.opcode)
            OP_INSERT: begin
              if (count_r == CNT_W'(TABLE_SIZE)) begin
                res_nxt   = mk_result(ST_FULL, '0, 1'b0, '0, '0, count_r);
                state_nxt = S_HOLD;
              end else begin
                state_nxt = S_INSERT;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_nxt   = mk_result(ST_EMPTY, '0, 1'b0, '0, '0, count_r);
                state_nxt = S_HOLD;
              end else begin
                state_nxt = S_REMOVE;
              end
            end
            OP_READ: state_nxt = S_READ;
            default: begin
              res_nxt   = mk_result(ST_OK, '0, 1'b0, '0, '0, count_r);
              state_nxt = S_HOLD;
            end
          endcase
        end
      end
      S_INSERT: begin
        if (!used_r[ptr_r]) begin
          ram_req.we      = 1'b1;
          used_nxt[ptr_r] = 1'b1;
          count_nxt       = count_r + 1'b1;
          res_nxt   = mk_result(ST_OK, IDX_W'(ptr_r), 1'b0, '0, '0, count_nxt);
          state_nxt = S_HOLD;
        end else begin
          ptr_nxt = next_slot(ptr_r);
        end
      end
      S_REMOVE: begin
        // reads issued back to back; each compare runs in the cycle after its read
        if (hit) begin
          used_nxt[cmp_ptr_r] = 1'b0;
          count_nxt           = count_r - 1'b1;
          res_nxt   = mk_result(ST_OK, IDX_W'(cmp_ptr_r), 1'b0, '0, '0, count_nxt);
          state_nxt = S_HOLD;
        end else if (iss_cnt_r != CNT_W'(TABLE_SIZE)) begin
          cmp_vld_nxt = 1'b1;
          cmp_ptr_nxt = ptr_r;
          ptr_nxt     = next_slot(ptr_r);
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end else if (!cmp_vld_r) begin
          res_nxt   = mk_result(ST_NOT_FOUND, '0, 1'b0, '0, '0, count_r);
          state_nxt = S_HOLD;
        end
      end
      S_READ: begin
        res_nxt = mk_result(ST_OK, sel_r, rd_vld,
                            rd_vld ? rd_key : '0,
                            rd_vld ? rd_val : '0, count_r);
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_data = res_r;

endmodule

@@ rtl/lph_out_stage.sv @@
module lph_out_stage
  import lph_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res_data,
  output logic      res_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// Channel  | Ports                          | Moves
// ---------+--------------------------------+------------------------------
// input    | in_valid, in_stall, in_data    | one operation per transaction
// result   | out_valid, out_stall, out_data | one result per transaction
//
// Insert probes one slot a cycle from home until a slot is free, then hands over.
// Remove streams one slot RAM read a cycle and compares each registered read
// against the key, then hands over.
// Read-slot reads on the single RAM read port; full/empty/nop go straight to hold.
// rst_n clears occupancy flags and count; slot RAM is not cleared.
// A finished result sits in the output register while the next op is taken.
module linear_probe_hash_table
  import lph_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ram_req_t         ram_req;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic             res_valid;
  logic             res_ready;
  out_item_t        res_data;

  lph_slot_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  lph_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .ram_req   (ram_req),
    .rd_key    (rd_key),
    .rd_val    (rd_val),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  lph_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

@@ rtl/lph_checker.sv @@
module lph_checker
  import lph_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= CNT_OUT_W'(TABLE_SIZE))
    else $error("entry count above table size");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.entry_count == CNT_OUT_W'(TABLE_SIZE))
    else $error("full status with free slots");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.entry_count == '0 && !out_data.slot_valid)
    else $error("empty status with entries present");

endmodule

bind linear_probe_hash_table lph_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
